// ===== rtl/heading_p_controller_with_snap_assert.svh =====
// Assertion macros for the heading controller.
`ifndef HEADING_P_CONTROLLER_WITH_SNAP_ASSERT_SVH
`define HEADING_P_CONTROLLER_WITH_SNAP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hpc_pkg.sv =====
// Shared types, constants and the reference angle table of the heading controller.
package hpc_pkg;

  // field widths
  localparam int unsigned MEAS_W  = 24;
  localparam int unsigned REQ_W   = 15;
  localparam int unsigned TGT_W   = 14;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned RATE_W  = 11;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned LIM_W   = 10;
  localparam int unsigned OFF_W   = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // serial divider geometry
  localparam int unsigned DVD_W   = 24;
  localparam int unsigned DSR_W   = 10;
  localparam int unsigned QUOT_W  = 14;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned ANG_W   = 17;

  localparam logic [STEP_W-1:0] STEPS_MEAS = 5'd24;
  localparam logic [STEP_W-1:0] STEPS_ERR  = 5'd14;
  localparam logic [DSR_W-1:0]  MEAS_DIV   = 10'd1000;

  // angles in milliradians
  localparam logic signed [ANG_W-1:0] ANG_45  = 17'sd785;
  localparam logic signed [ANG_W-1:0] ANG_180 = 17'sd3142;
  localparam logic signed [ANG_W-1:0] ANG_360 = 17'sd6283;

  localparam int unsigned REF_N = 5;
  localparam logic [2:0]  REF_FALLBACK = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST  = 8'd10;
  localparam logic [LIM_W-1:0]  LIMIT_RST = 10'd40;
  localparam logic [OFF_W-1:0]  OFF_RST   = 11'd140;

  // drive modes
  localparam logic [MODE_W-1:0] MODE_ROTATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BWD    = 2'd2;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // right angles from -180 deg; entry 5 is the fallback (+270 deg)
  function automatic logic signed [ANG_W-1:0] ref_ang(input logic [2:0] k);
    logic signed [ANG_W-1:0] a;
    unique case (k)
      3'd0:    a = -17'sd3142;
      3'd1:    a = -17'sd1571;
      3'd2:    a = 17'sd0;
      3'd3:    a = 17'sd1571;
      3'd4:    a = 17'sd3142;
      default: a = 17'sd4713;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/hpc_chan_if.sv =====
// Valid/ready channel interfaces for input and result words.
interface hpc_in_if;
  import hpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [MEAS_W-1:0] measured_heading;
  logic signed [REQ_W-1:0]  target_heading;
  logic [MODE_W-1:0]        drive_mode;

  modport source (output valid, cmd, measured_heading, target_heading, drive_mode,
                  input ready);
  modport sink (input valid, cmd, measured_heading, target_heading, drive_mode,
                output ready);
endinterface

interface hpc_out_if;
  import hpc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] yaw_rate;
  logic                     forward_valid;
  logic signed [RATE_W-1:0] forward_rate;
  logic signed [TGT_W-1:0]  stored_target;

  modport source (output valid, yaw_rate, forward_valid, forward_rate, stored_target,
                  input ready);
  modport sink (input valid, yaw_rate, forward_valid, forward_rate, stored_target,
                output ready);
endinterface

// ===== rtl/hpc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module hpc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hpc_pkg::div_req_t          req_i,
  output hpc_pkg::div_sts_t          sts_o,
  output logic [hpc_pkg::QUOT_W-1:0] quot_o
);
  import hpc_pkg::*;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DSR_W-1:0]  dsr_q, rem_q, rem_d;
  logic [DSR_W:0]    trial, diff;
  logic              qbit;

  // dividend shifts out at the top, quotient bits shift in at the bottom
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign qbit  = (trial >= {1'b0, dsr_q});
  assign rem_d = qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == STEP_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = dvd_q[QUOT_W-1:0];

endmodule

// ===== rtl/hpc_snap.sv =====
// Target wrap, right-angle reference pick and offset clamp for set words.
module hpc_snap (
  input  logic signed [hpc_pkg::REQ_W-1:0] tgt_i,
  input  logic        [hpc_pkg::OFF_W-1:0] off_i,
  output logic signed [hpc_pkg::TGT_W-1:0] tgt_o
);
  import hpc_pkg::*;

  logic signed [ANG_W-1:0] t, o, refv, dd, offs, res;
  logic signed [ANG_W-1:0] dk [REF_N];
  logic [REF_N-1:0]        hit;

  always_comb begin
    t = ANG_W'(tgt_i);
    if (t > ANG_180) begin
      o = t - ANG_360;
    end else if (t < -ANG_180) begin
      o = t + ANG_360;
    end else begin
      o = t;
    end

    for (int k = 0; k < REF_N; k++) begin
      dk[k]  = o - ref_ang(3'(k));
      hit[k] = (dk[k] <= ANG_45) && (dk[k] >= -ANG_45);
    end

    // first hit wins
    refv = ref_ang(REF_FALLBACK);
    for (int k = REF_N - 1; k >= 0; k--) begin
      if (hit[k]) begin
        refv = ref_ang(3'(k));
      end
    end

    offs = $signed({{(ANG_W-OFF_W){1'b0}}, off_i});
    dd   = refv - o;
    priority if (dd > offs) begin
      res = refv - offs;
    end else if (dd < -offs) begin
      res = refv + offs;
    end else begin
      res = o;
    end
  end

  assign tgt_o = res[TGT_W-1:0];

endmodule

// ===== rtl/heading_p_controller_with_snap.sv =====
// Heading controller top level: control sequencer, registers and output stage.
//
// One result word per input word. A set word (cmd = 1) wraps the requested
// heading into about +-pi, snaps it toward the first right angle from -180 deg
// that lies within 45 deg (else +270 deg), clamps it to max_offset_mrad of that
// angle and stores it with the drive mode; its result carries zero rates and
// the new target. A tick word (cmd = 0) reduces the measured heading from
// microradians to milliradians, wraps the error to the target, divides it by
// gain_divisor toward zero and limits it to +-the rate limit; in a pivot mode
// it also issues a forward drive of +-|yaw_rate|. Both divisions of a tick
// run through one bit-serial divider, 24 steps for the divide by 1000 and 14
// steps for the gain divide. A new word is accepted while the previous result
// still waits in the output register; the sequencer stalls only at its final
// step if that register is still full. Configuration writes (cfg_we_i,
// cfg_idx_i, cfg_data_i) take effect in the following cycle and are meant for
// idle periods; index 3 is ignored. A gain divisor of zero acts as one; drive
// mode 3 is stored and behaves like rotate only.
module heading_p_controller_with_snap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hpc_in_if.sink                        in_i,
  hpc_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [hpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hpc_pkg::CFG_W-1:0]     cfg_data_i
);
  import hpc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV1 = 6'b000010,
    S_WRAP = 6'b000100,
    S_DIV2 = 6'b001000,
    S_SNAP = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [GAIN_W-1:0] gain_q;
  logic [LIM_W-1:0]  lim_q;
  logic [OFF_W-1:0]  off_q;

  // controller state
  logic signed [TGT_W-1:0] target_q;
  logic [MODE_W-1:0]       mode_q;

  // per-word working registers
  logic                    div_start_q;
  logic [STEP_W-1:0]       div_steps_q;
  logic [DVD_W-1:0]        div_dvd_q;
  logic [DSR_W-1:0]        div_dsr_q;
  div_req_t                div_req;
  div_sts_t                div_sts;
  logic [QUOT_W-1:0]       quot;
  logic                    sign1_q, sign2_q;
  logic signed [REQ_W-1:0] req_tgt_q;
  logic [MODE_W-1:0]       req_mode_q;
  logic signed [ANG_W-1:0] draw_q;
  logic signed [RATE_W-1:0] res_turn_q, res_fwd_q;
  logic                    res_fv_q;

  // output register
  logic                     out_valid_q;
  logic signed [RATE_W-1:0] out_turn_q, out_fwd_q;
  logic                     out_fv_q;
  logic signed [TGT_W-1:0]  out_tgt_q;

  logic                    accept, load_out;
  logic                    in_div_step, fwd_mag_ok;
  logic [MEAS_W-1:0]       meas_mag;
  logic signed [ANG_W-1:0] psi, wr, wr_abs;
  logic signed [TGT_W-1:0] snap_tgt;
  logic [LIM_W-1:0]        mag_t;
  logic [RATE_W-1:0]       mag_ext;
  logic [DSR_W-1:0]        gain_eff;

  assign div_req = '{start: div_start_q, steps: div_steps_q, dividend: div_dvd_q,
                     divisor: div_dsr_q};

  hpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts),
    .quot_o (quot)
  );

  hpc_snap u_snap (
    .tgt_i (req_tgt_q),
    .off_i (off_q),
    .tgt_o (snap_tgt)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // |measured| for the divide by 1000; full negative range fits unsigned
  assign meas_mag = in_i.measured_heading[MEAS_W-1] ?
                    (~in_i.measured_heading + 1'b1) : in_i.measured_heading;

  // heading in mrad, truncated toward zero
  assign psi = sign1_q ? -$signed({{(ANG_W-QUOT_W){1'b0}}, quot})
                       :  $signed({{(ANG_W-QUOT_W){1'b0}}, quot});

  // error wrapped once into about +-pi
  always_comb begin
    if (draw_q > ANG_180) begin
      wr = draw_q - ANG_360;
    end else if (draw_q < -ANG_180) begin
      wr = draw_q + ANG_360;
    end else begin
      wr = draw_q;
    end
    wr_abs = wr[ANG_W-1] ? -wr : wr;
  end

  assign gain_eff = (gain_q == '0) ? DSR_W'(1) : {{(DSR_W-GAIN_W){1'b0}}, gain_q};
  // limiting the magnitude first is the same as a symmetric clamp
  assign mag_t    = (quot > {{(QUOT_W-LIM_W){1'b0}}, lim_q}) ? lim_q : quot[LIM_W-1:0];
  assign mag_ext  = {{(RATE_W-LIM_W){1'b0}}, mag_t};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = in_i.cmd ? S_SNAP : S_DIV1;
      S_DIV1: if (div_sts.done) state_d = S_WRAP;
      S_WRAP: state_d = S_DIV2;
      S_DIV2: if (div_sts.done) state_d = S_DONE;
      S_SNAP: state_d = S_DONE;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gain_q      <= GAIN_RST;
      lim_q       <= LIMIT_RST;
      off_q       <= OFF_RST;
      target_q    <= '0;
      mode_q      <= MODE_ROTATE;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      // divider kicks off after a tick accept and after the wrap step
      div_start_q <= (accept && !in_i.cmd) || (state_q == S_WRAP);

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GAIN:   gain_q <= cfg_data_i[GAIN_W-1:0];
          CFG_LIMIT:  lim_q  <= cfg_data_i[LIM_W-1:0];
          CFG_OFFSET: off_q  <= cfg_data_i[OFF_W-1:0];
          default: ;
        endcase
      end

      if (state_q == S_SNAP) begin
        target_q <= snap_tgt;
        mode_q   <= req_mode_q;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          sign1_q     <= in_i.measured_heading[MEAS_W-1];
          req_tgt_q   <= in_i.target_heading;
          req_mode_q  <= in_i.drive_mode;
          div_steps_q <= STEPS_MEAS;
          div_dvd_q   <= meas_mag;
          div_dsr_q   <= MEAS_DIV;
        end
      end
      S_DIV1: begin
        if (div_sts.done) begin
          draw_q <= ANG_W'(target_q) - psi;
        end
      end
      S_WRAP: begin
        sign2_q     <= wr[ANG_W-1];
        div_steps_q <= STEPS_ERR;
        div_dvd_q   <= {wr_abs[QUOT_W-1:0], {(DVD_W-QUOT_W){1'b0}}};
        div_dsr_q   <= gain_eff;
      end
      S_DIV2: begin
        if (div_sts.done) begin
          res_turn_q <= sign2_q ? $signed(~mag_ext + 1'b1) : $signed(mag_ext);
          res_fv_q   <= (mode_q == MODE_FWD) || (mode_q == MODE_BWD);
          priority if (mode_q == MODE_FWD) begin
            res_fwd_q <= $signed(mag_ext);
          end else if (mode_q == MODE_BWD) begin
            res_fwd_q <= $signed(~mag_ext + 1'b1);
          end else begin
            res_fwd_q <= '0;
          end
        end
      end
      S_SNAP: begin
        res_turn_q <= '0;
        res_fv_q   <= 1'b0;
        res_fwd_q  <= '0;
      end
      S_DONE: begin
        if (load_out) begin
          out_turn_q <= res_turn_q;
          out_fv_q   <= res_fv_q;
          out_fwd_q  <= res_fwd_q;
          out_tgt_q  <= target_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.yaw_rate      = out_turn_q;
  assign out_o.forward_valid = out_fv_q;
  assign out_o.forward_rate  = out_fwd_q;
  assign out_o.stored_target = out_tgt_q;

  assign in_div_step = (state_q == S_DIV1) || (state_q == S_DIV2);
  assign fwd_mag_ok  = (out_o.forward_rate == out_o.yaw_rate) ||
                       (out_o.forward_rate == -out_o.yaw_rate);

`include "heading_p_controller_with_snap_assert.svh"

  `HPC_ASSERT_NOW(a_idle_div_free, in_i.ready, !div_sts.busy, "divider busy while idle")
  `HPC_ASSERT_NOW(a_done_in_div, div_sts.done, in_div_step, "divider done outside a divide")
  `HPC_ASSERT_NEXT(a_set_to_snap, accept && in_i.cmd, state_q == S_SNAP, "set word missed snap")
  `HPC_ASSERT_NOW(a_fwd_mag, out_o.valid && out_o.forward_valid, fwd_mag_ok, "forward magnitude off")

endmodule
